// ----- rtl/psfa_pkg.sv -----
// Shared types, constants and helper functions of the page slot frame allocator.
package psfa_pkg;

    // Width of one word of the bitmap memories.
    localparam int WORD_W = 32;
    // Width of the word bit index.
    localparam int BIT_W = 5;
    // Page offset bits of an address.
    localparam int PAGE_SHIFT = 12;
    // Width of a page number in the address sums.
    localparam int PN_W = 25;
    // Width of a configuration register.
    localparam int CFG_W = 24;
    // Width of an address field.
    localparam int ADDR_W = 40;

    // Configuration register indexes.
    localparam logic CFG_FRAME_BASE = 1'b0;
    localparam logic CFG_VIRT_BASE  = 1'b1;

    // Sequencer states.
    typedef enum logic [8:0] {
        ST_CLEAR     = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_SSCAN_RD  = 9'b000000100,
        ST_SSCAN_CHK = 9'b000001000,
        ST_FRD       = 9'b000010000,
        ST_FCHK      = 9'b000100000,
        ST_SRD       = 9'b001000000,
        ST_SCHK      = 9'b010000000,
        ST_EMIT      = 9'b100000000
    } state_t;

    // Lowest clear bit of a word; only meaningful when at least one bit is clear.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/psfa_word_ram.sv -----
// Single-port synchronous word memory with registered read data.
module psfa_word_ram
    import psfa_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    // One access a cycle: write or read at the same address.
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/page_slot_frame_allocator_unit.sv -----
// Top level of the page slot frame allocator: sequencer, registers and the two bitmaps.
//
// A request for N pages (saturated to MAX_PAGES) first scans the slot bitmap one 32-bit
// word at a time until a word with a clear mark turns up, then for each page scans the
// frame bitmap from the current word, sets the frame bit, sets the slot bit by
// read-modify-write and loads one output word, waiting while the sink stalls. The frame
// scan restarts at word 0 for every request.
// Both bitmaps sit in single-port memories, so every bitmap access takes the one port.
// After reset a clearing pass runs before the first request is taken; configuration
// writes are taken at any time.
module page_slot_frame_allocator_unit
    import psfa_pkg::*;
#(
    parameter int FRAME_COUNT = 16384,
    parameter int SLOT_COUNT  = 4096,
    parameter int MAX_PAGES   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] page_count
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [39:0] page_vaddr, [79:40] frame_paddr
    output logic        m_tuser,   // [0] has_page
    output logic        m_tlast
);

    localparam int FWORDS = (FRAME_COUNT + WORD_W - 1) / WORD_W;
    localparam int SWORDS = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int FAW    = (FWORDS > 1) ? $clog2(FWORDS) : 1;
    localparam int SAW    = (SWORDS > 1) ? $clog2(SWORDS) : 1;
    localparam int CWORDS = (FWORDS > SWORDS) ? FWORDS : SWORDS;
    localparam int CAW    = $clog2(CWORDS + 1);
    localparam int SXW    = SAW + BIT_W;
    localparam int FXW    = FAW + BIT_W;
    localparam int PCW    = $clog2(MAX_PAGES + 1);
    localparam int CMPW   = (PCW > 5) ? PCW : 5;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  fbase_reg, vbase_reg;
    logic [CAW-1:0]    clr_reg, clr_next;
    logic [SAW:0]      sptr_reg, sptr_next;
    logic [FAW:0]      fptr_reg, fptr_next;
    logic [SXW-1:0]    slot_reg, slot_next;
    logic [PCW-1:0]    rem_reg, rem_next;
    logic [PN_W-1:0]   fp_reg, fp_next;
    logic [PN_W-1:0]   vpn_reg, vpn_next;
    logic              has_reg, has_next;
    logic              lst_reg, lst_next;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_va_reg, out_pa_reg;
    logic              out_has_reg, out_last_reg;
    logic              out_load;

    logic              f_we, s_we;
    logic [FAW-1:0]    f_addr;
    logic [SAW-1:0]    s_addr;
    logic [WORD_W-1:0] f_wdata, s_wdata, f_rdata, s_rdata;

    logic [CMPW-1:0]   req_count;
    logic [PCW-1:0]    req_sat;
    logic [BIT_W-1:0]  f_bit, s_bit;
    logic [FXW-1:0]    frame_idx;
    logic [WORD_W-1:0] f_pad, s_pad;
    logic              slot_end;

    // Bitmap memories.
    psfa_word_ram #(.DEPTH(FWORDS), .AW(FAW)) u_frame_ram (
        .clk   (clk),
        .we    (f_we),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    psfa_word_ram #(.DEPTH(SWORDS), .AW(SAW)) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .addr  (s_addr),
        .wdata (s_wdata),
        .rdata (s_rdata)
    );

    // Bits past the end of a bitmap are cleared to used, so no scan ever picks them.
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++) begin
            f_pad[i] = ((int'(clr_reg) * WORD_W + i) >= FRAME_COUNT);
            s_pad[i] = ((int'(clr_reg) * WORD_W + i) >= SLOT_COUNT);
        end
    end

    // Request size saturated to the page limit.
    always_comb
    begin
        req_count = CMPW'(s_tdata[4:0]);
        if (req_count > CMPW'(MAX_PAGES)) begin
            req_sat = PCW'(MAX_PAGES);
        end else begin
            req_sat = PCW'(req_count);
        end
    end

    assign f_bit     = lowest_zero(f_rdata);
    assign s_bit     = lowest_zero(s_rdata);
    assign frame_idx = {fptr_reg[FAW-1:0], f_bit};
    assign slot_end  = (slot_reg == SXW'(SLOT_COUNT - 1));
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    // Sequencer and memory port control.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        sptr_next  = sptr_reg;
        fptr_next  = fptr_reg;
        slot_next  = slot_reg;
        rem_next   = rem_reg;
        fp_next    = fp_reg;
        vpn_next   = vpn_reg;
        has_next   = has_reg;
        lst_next   = lst_reg;
        f_we       = 1'b0;
        s_we       = 1'b0;
        f_addr     = fptr_reg[FAW-1:0];
        s_addr     = sptr_reg[SAW-1:0];
        f_wdata    = f_rdata | (WORD_W'(1) << f_bit);
        s_wdata    = s_rdata | (WORD_W'(1) << slot_reg[BIT_W-1:0]);

        unique case (state_reg)
            ST_CLEAR: begin
                f_addr  = FAW'(clr_reg);
                s_addr  = SAW'(clr_reg);
                f_wdata = f_pad;
                s_wdata = s_pad;
                f_we    = (int'(clr_reg) < FWORDS);
                s_we    = (int'(clr_reg) < SWORDS);
                if (int'(clr_reg) == CWORDS - 1) begin
                    state_next = ST_IDLE;
                end
                clr_next = clr_reg + CAW'(1);
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next   = req_sat;
                    sptr_next  = '0;
                    fptr_next  = '0;
                    state_next = ST_SSCAN_RD;
                end
            end
            ST_SSCAN_RD: begin
                state_next = ST_SSCAN_CHK;
            end
            ST_SSCAN_CHK: begin
                if (~s_rdata != '0) begin
                    slot_next = {sptr_reg[SAW-1:0], s_bit};
                    if (rem_reg == '0) begin
                        vpn_next   = PN_W'(vbase_reg) + PN_W'({sptr_reg[SAW-1:0], s_bit});
                        fp_next    = '0;
                        has_next   = 1'b0;
                        lst_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FRD;
                    end
                end else if (int'(sptr_reg) == SWORDS - 1) begin
                    // Table full: report the window base.
                    vpn_next   = PN_W'(vbase_reg);
                    fp_next    = '0;
                    has_next   = 1'b0;
                    lst_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    sptr_next  = sptr_reg + (SAW+1)'(1);
                    state_next = ST_SSCAN_RD;
                end
            end
            ST_FRD: begin
                if (int'(fptr_reg) == FWORDS) begin
                    // Bitmap exhausted: the page maps frame 0.
                    fp_next    = '0;
                    state_next = ST_SRD;
                end else begin
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK: begin
                if (~f_rdata != '0) begin
                    f_we       = 1'b1;
                    fp_next    = PN_W'(fbase_reg) + PN_W'(frame_idx);
                    state_next = ST_SRD;
                end else begin
                    fptr_next  = fptr_reg + (FAW+1)'(1);
                    state_next = ST_FRD;
                end
            end
            ST_SRD: begin
                s_addr     = slot_reg[SXW-1:BIT_W];
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                s_addr     = slot_reg[SXW-1:BIT_W];
                s_we       = 1'b1;
                vpn_next   = PN_W'(vbase_reg) + PN_W'(slot_reg);
                has_next   = 1'b1;
                lst_next   = (rem_reg == PCW'(1)) || slot_end;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (lst_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        slot_next  = slot_reg + SXW'(1);
                        rem_next   = rem_reg - PCW'(1);
                        state_next = ST_FRD;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            sptr_reg  <= '0;
            fptr_reg  <= '0;
            slot_reg  <= '0;
            rem_reg   <= '0;
            lst_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sptr_reg  <= sptr_next;
            fptr_reg  <= fptr_next;
            slot_reg  <= slot_next;
            rem_reg   <= rem_next;
            lst_reg   <= lst_next;
        end
    end

    // Payload of the word being built.
    always_ff @(posedge clk)
    begin
        fp_reg  <= fp_next;
        vpn_reg <= vpn_next;
        has_reg <= has_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fbase_reg <= CFG_W'(16384);
            vbase_reg <= CFG_W'(262144);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_BASE: fbase_reg <= cfg_data;
                CFG_VIRT_BASE:  vbase_reg <= cfg_data;
                default:        fbase_reg <= fbase_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_va_reg   <= {3'b000, vpn_reg, {PAGE_SHIFT{1'b0}}};
            out_pa_reg   <= {3'b000, fp_reg, {PAGE_SHIFT{1'b0}}};
            out_has_reg  <= has_reg;
            out_last_reg <= lst_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pa_reg, out_va_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

    // An accepted request always starts with the slot scan.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SSCAN_RD))
        else $error("request did not start the slot scan");

    // The frame bitmap is written only by the clearing pass or a frame take.
    a_frame_write: assert property (@(posedge clk) disable iff (!rst_n)
        f_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_FCHK)))
        else $error("unexpected frame bitmap write");

    // A new output word is loaded only from the emit state.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("output loaded outside the emit state");

    // No request is taken during the clearing pass.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request taken while clearing");

endmodule
